>>> hdl/iptv_pkg.sv
`timescale 1ns / 1ps

package iptv_pkg;

  // Verdict codes
  localparam logic [1:0] VERDICT_NEITHER = 2'd0;
  localparam logic [1:0] VERDICT_V4      = 2'd1;
  localparam logic [1:0] VERDICT_V6      = 2'd2;

  // Character codes
  localparam logic [7:0] CHR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHR_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CHR_LO_A  = 8'h61;  // 'a'
  localparam logic [7:0] CHR_LO_F  = 8'h66;  // 'f'
  localparam logic [7:0] CHR_UP_A  = 8'h41;  // 'A'
  localparam logic [7:0] CHR_UP_F  = 8'h46;  // 'F'
  localparam logic [7:0] CHR_DOT   = 8'h2E;  // '.'
  localparam logic [7:0] CHR_COLON = 8'h3A;  // ':'

  // Group limits and counter saturation points
  localparam logic [8:0]  V4_MAX_VALUE = 9'd255;
  localparam logic [8:0]  VALUE_SAT    = 9'd256;
  localparam logic [2:0]  LEN_SAT      = 3'd7;
  localparam logic [2:0]  DOT_SAT      = 3'd7;
  localparam logic [3:0]  COLON_SAT    = 4'd15;
  localparam logic [2:0]  V4_DOTS      = 3'd3;
  localparam logic [3:0]  V6_COLONS    = 4'd7;
  localparam logic [2:0]  V6_MAX_LEN   = 3'd4;

  // Outcome of one scanned character
  typedef struct packed {
    logic       fire;     // the beat closes a text and yields a verdict
    logic [1:0] verdict;
  } scan_res_t;

  // An IPv4 group that is empty, has a leading zero or is too large
  function automatic logic v4_group_bad(input logic [2:0] len, input logic [8:0] val,
                                        input logic lz);
    v4_group_bad = (len == 3'd0) || (lz && (len != 3'd1)) || (val > V4_MAX_VALUE);
  endfunction

  // An IPv6 group needs one to four hex digits
  function automatic logic v6_group_bad(input logic [2:0] len);
    v6_group_bad = (len == 3'd0) || (len > V6_MAX_LEN);
  endfunction

endpackage

>>> hdl/ip_address_text_validator.sv
`timescale 1ns / 1ps

// Channel   Direction  Ports                                   Beat
// in        input      in_valid, in_stall, in_character,       one character of the text
//                      in_last_char
// out       output     out_valid, out_stall, out_verdict       one verdict per text
//
// One character is taken every cycle while in_stall is low; a finished text's verdict
// is registered into the output register, or into the skid if that one is still held.
// The character scan is a single combinational step off the state registers.
// A one-entry skid register keeps input running while a verdict waits; in_stall
// rises only when both the output and skid registers hold verdicts.
// Reset is synchronous on rst_n low and clears the scan state and both
// registers' valid flags; no clearing pass is needed.

module ip_address_text_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_character,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_verdict
);

  iptv_pkg::scan_res_t res;

  logic       in_acc, out_take;
  logic       out_valid_r, skid_valid_r;
  logic [1:0] out_verdict_r, skid_verdict_r;

  assign in_acc   = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  // Scan one character per accepted beat
  iptv_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_acc  (in_acc),
    .character (in_character),
    .last_char (in_last_char),
    .res       (res)
  );

  // Output register with a one-entry skid behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_verdict_r <= skid_verdict_r;
        skid_valid_r  <= 1'b0;
      end
    end else if (res.fire) begin
      if (!out_valid_r || out_take) begin
        out_valid_r   <= 1'b1;
        out_verdict_r <= res.verdict;
      end else begin
        skid_valid_r   <= 1'b1;
        skid_verdict_r <= res.verdict;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

`ifndef SYNTHESIS
  // The skid only fills behind a waiting verdict
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a verdict while output register is empty");

  // A drained output refills from the skid
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_take) |=> (out_valid_r && !skid_valid_r))
    else $error("skid verdict lost when output drained");

  // A finished text reaches the output register or the skid
  a_verdict_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res.fire |=> (out_valid_r || skid_valid_r))
    else $error("verdict of a finished text was dropped");

  // Only defined verdict codes leave the block
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_verdict_r == iptv_pkg::VERDICT_NEITHER ||
                     out_verdict_r == iptv_pkg::VERDICT_V4 ||
                     out_verdict_r == iptv_pkg::VERDICT_V6))
    else $error("undefined verdict code on output");
`endif

endmodule

>>> hdl/iptv_scan.sv
`timescale 1ns / 1ps

module iptv_scan (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  beat_acc,
  input  logic [7:0]            character,
  input  logic                  last_char,
  output iptv_pkg::scan_res_t   res
);

  logic       v4_r, v6_r, lz_r;
  logic [2:0] dot_r, len_r;
  logic [3:0] colon_r;
  logic [8:0] val_r;

  logic       v4_nxt, v6_nxt, lz_nxt;
  logic [2:0] dot_nxt, len_nxt;
  logic [3:0] colon_nxt;
  logic [8:0] val_nxt;

  logic        is_digit, is_hex;
  logic [3:0]  digit;
  logic [11:0] val_wide;
  logic [2:0]  len_bump;
  logic        fin_v4, fin_v6;

  // Classify the character
  assign is_digit = (character >= iptv_pkg::CHR_ZERO) && (character <= iptv_pkg::CHR_NINE);
  assign is_hex   = ((character >= iptv_pkg::CHR_LO_A) && (character <= iptv_pkg::CHR_LO_F)) ||
                    ((character >= iptv_pkg::CHR_UP_A) && (character <= iptv_pkg::CHR_UP_F));
  assign digit    = character[3:0];
  assign len_bump = (len_r < iptv_pkg::LEN_SAT) ? len_r + 3'd1 : len_r;

  // value * 10 + digit, by shifts and adds
  assign val_wide = ({3'd0, val_r} << 3) + ({3'd0, val_r} << 1) + {8'd0, digit};

  // Advance the per-group and per-text state by one character
  always_comb begin
    v4_nxt    = v4_r;
    v6_nxt    = v6_r;
    lz_nxt    = lz_r;
    dot_nxt   = dot_r;
    colon_nxt = colon_r;
    len_nxt   = len_r;
    val_nxt   = val_r;
    if (is_digit) begin
      if ((len_r == 3'd0) && (digit == 4'd0)) begin
        lz_nxt = 1'b1;
      end
      len_nxt = len_bump;
      val_nxt = (val_wide > {3'd0, iptv_pkg::VALUE_SAT}) ? iptv_pkg::VALUE_SAT : val_wide[8:0];
    end else if (is_hex) begin
      v4_nxt  = 1'b0;
      len_nxt = len_bump;
    end else if (character == iptv_pkg::CHR_DOT) begin
      v6_nxt = 1'b0;
      if (iptv_pkg::v4_group_bad(len_r, val_r, lz_r)) begin
        v4_nxt = 1'b0;
      end
      dot_nxt = (dot_r < iptv_pkg::DOT_SAT) ? dot_r + 3'd1 : dot_r;
      len_nxt = 3'd0;
      val_nxt = 9'd0;
      lz_nxt  = 1'b0;
    end else if (character == iptv_pkg::CHR_COLON) begin
      v4_nxt = 1'b0;
      if (iptv_pkg::v6_group_bad(len_r)) begin
        v6_nxt = 1'b0;
      end
      colon_nxt = (colon_r < iptv_pkg::COLON_SAT) ? colon_r + 4'd1 : colon_r;
      len_nxt   = 3'd0;
      val_nxt   = 9'd0;
      lz_nxt    = 1'b0;
    end else begin
      v4_nxt = 1'b0;
      v6_nxt = 1'b0;
    end
  end

  // Close the final group and judge the whole text
  assign fin_v4 = v4_nxt && !iptv_pkg::v4_group_bad(len_nxt, val_nxt, lz_nxt) &&
                  (dot_nxt == iptv_pkg::V4_DOTS);
  assign fin_v6 = v6_nxt && !iptv_pkg::v6_group_bad(len_nxt) &&
                  (colon_nxt == iptv_pkg::V6_COLONS);

  always_comb begin
    res.fire = beat_acc && last_char;
    priority if (fin_v4) begin
      res.verdict = iptv_pkg::VERDICT_V4;
    end else if (fin_v6) begin
      res.verdict = iptv_pkg::VERDICT_V6;
    end else begin
      res.verdict = iptv_pkg::VERDICT_NEITHER;
    end
  end

  // Hold state between beats; return to the start after the last beat
  always_ff @(posedge clk) begin
    if (!rst_n || (beat_acc && last_char)) begin
      v4_r    <= 1'b1;
      v6_r    <= 1'b1;
      dot_r   <= 3'd0;
      colon_r <= 4'd0;
      len_r   <= 3'd0;
      val_r   <= 9'd0;
      lz_r    <= 1'b0;
    end else if (beat_acc) begin
      v4_r    <= v4_nxt;
      v6_r    <= v6_nxt;
      dot_r   <= dot_nxt;
      colon_r <= colon_nxt;
      len_r   <= len_nxt;
      val_r   <= val_nxt;
      lz_r    <= lz_nxt;
    end
  end

endmodule

>>> sim/tb_ip_address_text_validator.sv
`timescale 1ns / 1ps

module tb_ip_address_text_validator;

  // Tracks both readings of the text seen so far and queues one verdict per text
  class verdict_board;
    bit         v4_ok;
    bit         v6_ok;
    bit   [2:0] dots;
    bit   [3:0] colons;
    bit   [2:0] glen;
    bit   [8:0] gval;
    bit         glz;
    logic [1:0] expected_verdicts[$];
    int         fails;

    function new();
      fails = 0;
      restart();
    endfunction

    function void clear_group();
      glen = 3'd0;
      gval = 9'd0;
      glz  = 1'b0;
    endfunction

    function void restart();
      v4_ok  = 1'b1;
      v6_ok  = 1'b1;
      dots   = 3'd0;
      colons = 4'd0;
      clear_group();
    endfunction

    function void bump_len();
      if (glen < iptv_pkg::LEN_SAT) glen = glen + 3'd1;
    endfunction

    // Reject an empty group, a padded group or one above 255
    function void end_v4_group();
      if (glen == 3'd0) v4_ok = 1'b0;
      if (glz && glen != 3'd1) v4_ok = 1'b0;
      if (gval > iptv_pkg::V4_MAX_VALUE) v4_ok = 1'b0;
    endfunction

    function void end_v6_group();
      if (glen < 3'd1 || glen > iptv_pkg::V6_MAX_LEN) v6_ok = 1'b0;
    endfunction

    // Advance the scan by one accepted character
    function void note_char(logic [7:0] ch, logic lst);
      int d;
      int v;
      if (ch >= iptv_pkg::CHR_ZERO && ch <= iptv_pkg::CHR_NINE) begin
        d = int'(ch - iptv_pkg::CHR_ZERO);
        if (glen == 3'd0 && d == 0) glz = 1'b1;
        bump_len();
        v = int'(gval) * 10 + d;
        gval = (v > int'(iptv_pkg::VALUE_SAT)) ? iptv_pkg::VALUE_SAT : 9'(v);
      end else if ((ch >= iptv_pkg::CHR_LO_A && ch <= iptv_pkg::CHR_LO_F) ||
                   (ch >= iptv_pkg::CHR_UP_A && ch <= iptv_pkg::CHR_UP_F)) begin
        v4_ok = 1'b0;
        bump_len();
      end else if (ch == iptv_pkg::CHR_DOT) begin
        v6_ok = 1'b0;
        end_v4_group();
        if (dots < iptv_pkg::DOT_SAT) dots = dots + 3'd1;
        clear_group();
      end else if (ch == iptv_pkg::CHR_COLON) begin
        v4_ok = 1'b0;
        end_v6_group();
        if (colons < iptv_pkg::COLON_SAT) colons = colons + 4'd1;
        clear_group();
      end else begin
        v4_ok = 1'b0;
        v6_ok = 1'b0;
      end

      if (lst) begin
        end_v4_group();
        end_v6_group();
        if (dots != iptv_pkg::V4_DOTS) v4_ok = 1'b0;
        if (colons != iptv_pkg::V6_COLONS) v6_ok = 1'b0;
        if (v4_ok) expected_verdicts.push_back(iptv_pkg::VERDICT_V4);
        else if (v6_ok) expected_verdicts.push_back(iptv_pkg::VERDICT_V6);
        else expected_verdicts.push_back(iptv_pkg::VERDICT_NEITHER);
        restart();
      end
    endfunction

    // Compare one delivered verdict with the oldest pending one
    function void check_verdict(logic [1:0] got);
      logic [1:0] want;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: verdict %0d delivered with no text pending", $time, got);
        fails++;
      end else begin
        want = expected_verdicts.pop_front();
        if (got !== want) begin
          $display("%0t: verdict mismatch: expected %0d, actual %0d", $time, want, got);
          fails++;
        end
      end
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] in_character = 8'd0;
  logic       in_last_char = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [1:0] out_verdict;

  verdict_board board;
  bit           send_calm = 1'b0;
  bit           sink_calm = 1'b0;

  ip_address_text_validator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_character (in_character),
    .in_last_char (in_last_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_verdict  (out_verdict)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Draw a random wait; calm stretches draw none
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 63) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 19));
  endfunction

  function automatic void push_str(ref logic [7:0] t[$], input string s);
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
  endfunction

  // Build one text: mostly dotted or colon-separated shapes, some noise, some damage
  function automatic void build_text(ref logic [7:0] t[$]);
    int    kind;
    int    groups;
    int    n;
    int    d;
    string g;
    string border;
    border = "/;@GgZz[{";
    t.delete();
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      groups = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 4;
      for (int j = 0; j < groups; j++) begin
        if (j > 0) t.push_back(iptv_pkg::CHR_DOT);
        case ($urandom_range(0, 11))
          0:       g = "";
          1:       g = $sformatf("0%0d", $urandom_range(0, 99));
          2:       g = $sformatf("%0d", $urandom_range(256, 999));
          3:       g = $sformatf("%0d", $urandom_range(1000, 99999999));
          4:       g = ($urandom_range(0, 1) != 0) ? "255" : "256";
          5:       g = "0";
          default: g = $sformatf("%0d", $urandom_range(0, 255));
        endcase
        push_str(t, g);
      end
    end else if (kind < 8) begin
      groups = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 20) : 8;
      for (int j = 0; j < groups; j++) begin
        if (j > 0) t.push_back(iptv_pkg::CHR_COLON);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 9) : $urandom_range(1, 4);
        repeat (n) begin
          d = $urandom_range(0, 15);
          if (d < 10) t.push_back(8'(iptv_pkg::CHR_ZERO + d));
          else t.push_back(8'((($urandom_range(0, 1) != 0) ? iptv_pkg::CHR_UP_A :
                                                             iptv_pkg::CHR_LO_A) + d - 10));
        end
      end
    end else begin
      n = $urandom_range(1, 20);
      repeat (n) begin
        case ($urandom_range(0, 4))
          0: t.push_back(8'($urandom_range(0, 255)));
          1: t.push_back(8'(iptv_pkg::CHR_ZERO + $urandom_range(0, 9)));
          2: t.push_back(iptv_pkg::CHR_DOT);
          3: t.push_back(iptv_pkg::CHR_COLON);
          default: t.push_back(border[$urandom_range(0, border.len() - 1)]);
        endcase
      end
    end
    if (t.size() == 0) t.push_back(iptv_pkg::CHR_ZERO);
    // Corrupt one byte now and then
    if ($urandom_range(0, 5) == 0) t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
  endfunction

  // Present one character and hold it until the block takes it
  task automatic send_char(input logic [7:0] ch, input logic lst);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_character <= ch;
    in_last_char <= lst;
    do @(posedge clk); while (in_stall);
    board.note_char(ch, lst);
    @(negedge clk);
  endtask

  task automatic send_text(input logic [7:0] t[$]);
    for (int i = 0; i < t.size(); i++) send_char(t[i], i == t.size() - 1);
  endtask

  // Hold off input until every pending verdict has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Verdict sink: random stall before each beat, check on acceptance
  initial begin : verdict_sink
    int n;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      n = draw_wait(sink_calm);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      board.check_verdict(out_verdict);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [7:0] txt[$];
    int         sent;
    bit         mid_drained;
    board = new();
    sent = 0;
    mid_drained = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Single-byte texts at both ends of the byte range, then minimal valid addresses
    txt = {8'h00};
    send_text(txt);
    txt = {8'hFF};
    send_text(txt);
    txt.delete();
    push_str(txt, "0.0.0.0");
    send_text(txt);
    txt.delete();
    push_str(txt, "F:a:0:0:0:0:0:9");
    send_text(txt);
    wait_drain();

    // Random texts
    while (sent < 1200) begin
      build_text(txt);
      send_text(txt);
      sent += txt.size();
      if (!mid_drained && sent >= 600) begin
        wait_drain();
        mid_drained = 1'b1;
      end
    end
    wait_drain();
    repeat (10) @(posedge clk);

    if (board.fails == 0) begin
      $display("tb_ip_address_text_validator: PASS");
    end else begin
      $display("tb_ip_address_text_validator: FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #5_000_000;
    $display("tb_ip_address_text_validator: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
hdl/iptv_pkg.sv
hdl/iptv_scan.sv
hdl/ip_address_text_validator.sv
sim/tb_ip_address_text_validator.sv
